### src/mfsc_pkg.sv
// shared types, constants and microcode table for the marker follow speed controller
package mfsc_pkg;

  // default build values
  localparam int DefTicksPerSecond = 10;
  localparam int DefFractionBits   = 12;

  // fixed field widths
  localparam int SpeedW  = 16;
  localparam int TargetW = 15;
  localparam int QuietW  = 8;
  localparam int SqW     = 32;
  localparam int RootW   = 16;
  localparam int RangeW  = 17;
  localparam int ErrW    = 18;
  localparam int TenW    = 20;

  // divide by ten through a reciprocal, one correction step afterwards
  localparam int RecipMul   = 52428;
  localparam int RecipW     = 16;
  localparam int RecipShift = 19;
  localparam int ProdW      = TenW + RecipW;

  localparam logic [TargetW-1:0] TargetReset = 15'd4096;

  // input word
  typedef struct packed {
    logic                     operation;
    logic signed [SpeedW-1:0] marker_forward;
    logic signed [SpeedW-1:0] marker_lateral;
    logic                     obstacle_present;
  } in_word_t;

  // result word
  typedef struct packed {
    logic signed [SpeedW-1:0] linear_speed;
    logic signed [SpeedW-1:0] angular_speed;
    logic                     at_target;
    logic                     marker_seen;
    logic                     search_done;
  } out_word_t;

  // operation codes of the input word
  typedef enum logic {
    ITEM_SAMPLE = 1'b0,
    ITEM_TICK   = 1'b1
  } item_e;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LATCH,
    OP_SQ_F,
    OP_SQ_L,
    OP_ROOT_GO,
    OP_TENTHS,
    OP_RECIP,
    OP_RANGE,
    OP_ERR,
    OP_SAMPLE,
    OP_TICK_CNT,
    OP_TICK_CMD,
    OP_EMIT,
    OP_TICK_POST
  } dp_op_e;

  // jump conditions
  typedef enum logic [2:0] {
    C_NONE,
    C_NO_ITEM,
    C_TICK,
    C_ROOT_BUSY,
    C_OUT_BUSY,
    C_NO_EMIT
  } cond_e;

  // program steps
  typedef enum logic [3:0] {
    S_WAIT,
    S_SPLIT,
    S_SQ_F,
    S_SQ_L,
    S_ROOT_GO,
    S_ROOT_WAIT,
    S_TENTHS,
    S_RECIP,
    S_RANGE,
    S_ERR,
    S_SAMPLE,
    S_SMP_EMIT,
    S_TICK_CNT,
    S_TICK_CMD,
    S_TICK_EMIT,
    S_TICK_POST
  } step_e;

  // one control word
  typedef struct packed {
    dp_op_e op;
    cond_e  cond;
    step_e  target;
    logic   fin;
  } ctrl_word_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic in_valid;
    logic is_tick;
    logic root_busy;
    logic out_busy;
    logic no_emit;
  } status_t;

  // microcode program
  function automatic ctrl_word_t mc_rom(step_e s);
    ctrl_word_t cw;
    cw = '{op: OP_NOP, cond: C_NONE, target: S_WAIT, fin: 1'b0};
    case (s)
      S_WAIT:      cw = '{op: OP_LATCH,     cond: C_NO_ITEM,   target: S_WAIT,      fin: 1'b0};
      S_SPLIT:     cw = '{op: OP_NOP,       cond: C_TICK,      target: S_TICK_CNT,  fin: 1'b0};
      S_SQ_F:      cw = '{op: OP_SQ_F,      cond: C_NONE,      target: S_WAIT,      fin: 1'b0};
      S_SQ_L:      cw = '{op: OP_SQ_L,      cond: C_NONE,      target: S_WAIT,      fin: 1'b0};
      S_ROOT_GO:   cw = '{op: OP_ROOT_GO,   cond: C_NONE,      target: S_WAIT,      fin: 1'b0};
      S_ROOT_WAIT: cw = '{op: OP_NOP,       cond: C_ROOT_BUSY, target: S_ROOT_WAIT, fin: 1'b0};
      S_TENTHS:    cw = '{op: OP_TENTHS,    cond: C_NONE,      target: S_WAIT,      fin: 1'b0};
      S_RECIP:     cw = '{op: OP_RECIP,     cond: C_NONE,      target: S_WAIT,      fin: 1'b0};
      S_RANGE:     cw = '{op: OP_RANGE,     cond: C_NONE,      target: S_WAIT,      fin: 1'b0};
      S_ERR:       cw = '{op: OP_ERR,       cond: C_NONE,      target: S_WAIT,      fin: 1'b0};
      S_SAMPLE:    cw = '{op: OP_SAMPLE,    cond: C_NONE,      target: S_WAIT,      fin: 1'b0};
      S_SMP_EMIT:  cw = '{op: OP_EMIT,      cond: C_OUT_BUSY,  target: S_SMP_EMIT,  fin: 1'b1};
      S_TICK_CNT:  cw = '{op: OP_TICK_CNT,  cond: C_NONE,      target: S_WAIT,      fin: 1'b0};
      S_TICK_CMD:  cw = '{op: OP_TICK_CMD,  cond: C_NO_EMIT,   target: S_TICK_POST, fin: 1'b0};
      S_TICK_EMIT: cw = '{op: OP_EMIT,      cond: C_OUT_BUSY,  target: S_TICK_EMIT, fin: 1'b0};
      S_TICK_POST: cw = '{op: OP_TICK_POST, cond: C_NONE,      target: S_WAIT,      fin: 1'b1};
      default:     cw = '{op: OP_NOP,       cond: C_NONE,      target: S_WAIT,      fin: 1'b1};
    endcase
    return cw;
  endfunction

  // clamp an 18-bit signed value to the 16-bit signed range
  function automatic logic signed [SpeedW-1:0] sat16(logic signed [ErrW-1:0] v);
    logic signed [SpeedW-1:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[SpeedW-1:0];
    end
    return r;
  endfunction

endpackage

### src/mfsc_in_if.sv
// input word channel
interface mfsc_in_if;
  import mfsc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic signed [SpeedW-1:0] marker_forward;
  logic signed [SpeedW-1:0] marker_lateral;
  logic                     obstacle_present;

  modport source (
    output valid, operation, marker_forward, marker_lateral, obstacle_present,
    input  ready
  );

  modport sink (
    input  valid, operation, marker_forward, marker_lateral, obstacle_present,
    output ready
  );
endinterface

### src/mfsc_out_if.sv
// result word channel
interface mfsc_out_if;
  import mfsc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [SpeedW-1:0] linear_speed;
  logic signed [SpeedW-1:0] angular_speed;
  logic                     at_target;
  logic                     marker_seen;
  logic                     search_done;

  modport source (
    output valid, linear_speed, angular_speed, at_target, marker_seen, search_done,
    input  ready
  );

  modport sink (
    input  valid, linear_speed, angular_speed, at_target, marker_seen, search_done,
    output ready
  );
endinterface

### src/mfsc_root.sv
// iterative integer square root, one result bit per cycle
module mfsc_root (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [mfsc_pkg::SqW-1:0]    radicand_i,
  output logic                        busy_o,
  output logic [mfsc_pkg::RootW-1:0]  root_o
);
  import mfsc_pkg::*;

  localparam int CntW = $clog2(RootW);
  localparam int RemW = RootW + 2;

  logic                busy_q, busy_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [SqW-1:0]      x_q, x_d;
  logic [RemW-1:0]     rem_q, rem_d;
  logic [RootW-1:0]    root_q, root_d;
  logic [RemW+1:0]     rem_t;
  logic [RemW+1:0]     trial;

  // one restoring step
  always_comb begin
    rem_t  = {rem_q, x_q[SqW-1 -: 2]};
    trial  = (RemW + 2)'({root_q, 2'b01});
    busy_d = busy_q;
    cnt_d  = cnt_q;
    x_d    = x_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      x_d    = radicand_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      x_d   = {x_q[SqW-3:0], 2'b00};
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(RootW - 1)) begin
        busy_d = 1'b0;
      end
      if (rem_t >= trial) begin
        rem_d  = RemW'(rem_t - trial);
        root_d = {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_d  = RemW'(rem_t);
        root_d = {root_q[RootW-2:0], 1'b0};
      end
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // working values
  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign busy_o = busy_q;
  assign root_o = root_q;
endmodule

### src/mfsc_seq.sv
// microcode sequencer: step counter, program table and conditional jumps
module mfsc_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mfsc_pkg::status_t status_i,
  output mfsc_pkg::dp_op_e  op_o,
  output logic              idle_o
);
  import mfsc_pkg::*;

  step_e      pc_q, pc_d;
  ctrl_word_t cw;
  logic       take;

  // condition select and next step
  always_comb begin
    cw = mc_rom(pc_q);
    case (cw.cond)
      C_NONE:      take = 1'b0;
      C_NO_ITEM:   take = !status_i.in_valid;
      C_TICK:      take = status_i.is_tick;
      C_ROOT_BUSY: take = status_i.root_busy;
      C_OUT_BUSY:  take = status_i.out_busy;
      C_NO_EMIT:   take = status_i.no_emit;
      default:     take = 1'b0;
    endcase
    if (take) begin
      pc_d = cw.target;
    end else if (cw.fin) begin
      pc_d = S_WAIT;
    end else begin
      pc_d = step_e'(4'(pc_q) + 4'd1);
    end
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= S_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign op_o   = cw.op;
  assign idle_o = (pc_q == S_WAIT);
endmodule

### src/mfsc_dp.sv
// datapath: range, speed commands, search timer and result register
module mfsc_dp #(
  parameter int TicksPerSecond = mfsc_pkg::DefTicksPerSecond,
  parameter int FractionBits   = mfsc_pkg::DefFractionBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mfsc_pkg::dp_op_e              op_i,
  input  mfsc_pkg::in_word_t            in_word_i,
  input  logic                          in_valid_i,
  input  logic [mfsc_pkg::TargetW-1:0]  target_i,
  input  logic                          out_ready_i,
  output mfsc_pkg::out_word_t           out_word_o,
  output logic                          out_valid_o,
  output mfsc_pkg::status_t             status_o
);
  import mfsc_pkg::*;

  // fixed-point constants
  localparam int Scale   = 1 << FractionBits;
  localparam int Tol     = (Scale + 50) / 100;
  localparam int TurnRaw = (157 * Scale + 50) / 100;
  localparam logic signed [ErrW-1:0]   TolPos    = ErrW'(Tol);
  localparam logic signed [ErrW-1:0]   TolNeg    = -ErrW'(Tol);
  localparam logic signed [SpeedW-1:0] BackSpeed = SpeedW'(-((3 * Scale + 5) / 10));
  localparam logic signed [SpeedW-1:0] TurnPos   = SpeedW'((TurnRaw > 32767) ? 32767 : TurnRaw);
  localparam logic signed [SpeedW-1:0] TurnNeg   =
    SpeedW'((TurnRaw > 32768) ? -32768 : -TurnRaw);
  localparam logic [TenW-1:0] Half    = TenW'(Scale / 2);
  localparam logic [TenW-1:0] LowMask = TenW'(Scale - 1);

  // tick thresholds
  localparam logic [QuietW-1:0] T2  = QuietW'(2 * TicksPerSecond);
  localparam logic [QuietW-1:0] T3  = QuietW'(3 * TicksPerSecond);
  localparam logic [QuietW-1:0] T8  = QuietW'(8 * TicksPerSecond);
  localparam logic [QuietW-1:0] T14 = QuietW'(14 * TicksPerSecond);
  localparam logic [QuietW-1:0] T20 = QuietW'(20 * TicksPerSecond);

  // latched input word
  logic signed [SpeedW-1:0] fwd_q, lat_q;
  logic                     obst_q, tick_q;

  // sample pipeline values
  logic [SqW-1:0]            acc_q, acc_d;
  logic [TenW-1:0]           x_q, x_d;
  logic [ProdW-1:0]          prod_q;
  logic [RangeW-1:0]         range_q, range_d;
  logic signed [ErrW-1:0]    err_q, err_d;
  logic                      near_q, big_q, small_q;
  logic                      near_d, big_d, small_d;

  // controller state
  logic                      seen_q, seen_d;
  logic                      reached_q, reached_d;
  logic                      sweep_q, sweep_d;
  logic [QuietW-1:0]         quiet_q, quiet_d;
  logic signed [SpeedW-1:0]  held_lin_q, held_lin_d;
  logic signed [SpeedW-1:0]  held_ang_q, held_ang_d;
  logic                      turn_neg_q, turn_neg_d;
  logic                      turn_pos_q, turn_pos_d;
  logic                      set_sweep_q, set_sweep_d;
  logic                      drop_q, drop_d;

  // result register
  logic                      out_valid_q;
  out_word_t                 out_word_q;
  logic                      out_busy, out_load;

  // shared squaring multiplier and root unit
  logic signed [SpeedW-1:0]  sq_src;
  logic signed [SqW-1:0]     sq;
  logic [RootW-1:0]          root;
  logic                      root_busy;

  // helpers
  logic [TenW-1:0]           ten_sum;
  logic [RangeW-1:0]         quo;
  logic [TenW-1:0]           rem10;
  logic [QuietW:0]           d_wide;
  logic [QuietW-1:0]         d;
  logic signed [SpeedW-1:0]  lin_cmd;
  logic signed [SpeedW-1:0]  ang_cmd;
  logic                      hunting;

  mfsc_root u_root (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (op_i == OP_ROOT_GO),
    .radicand_i (acc_q),
    .busy_o     (root_busy),
    .root_o     (root)
  );

  // squares
  always_comb begin
    sq_src = (op_i == OP_SQ_F) ? fwd_q : lat_q;
    sq     = sq_src * sq_src;
    acc_d  = (op_i == OP_SQ_F) ? SqW'(sq) : acc_q + SqW'(sq);
  end

  // tenths rounding and divide by ten
  always_comb begin
    ten_sum = TenW'({root, 3'b000}) + TenW'({root, 1'b0}) + Half;
    x_d     = (ten_sum & ~LowMask) + TenW'(5);
    quo     = prod_q[RecipShift +: RangeW];
    rem10   = x_q - (TenW'({quo, 3'b000}) + TenW'({quo, 1'b0}));
    range_d = (rem10 >= TenW'(10)) ? quo + RangeW'(1) : quo;
  end

  // error and band compares
  always_comb begin
    err_d   = $signed({1'b0, range_q}) - $signed({3'b000, target_i});
    near_d  = (err_d <= TolPos) && (err_d >= TolNeg);
    big_d   = 19'({range_q, 1'b0}) > (19'({target_i, 1'b0}) + 19'(target_i));
    small_d = (24'(range_q) * 24'd100) < (24'(target_i) * 24'd95);
  end

  // speed commands of a sample
  always_comb begin
    if (big_q) begin
      lin_cmd = sat16(err_q);
    end else if (small_q) begin
      lin_cmd = BackSpeed;
    end else begin
      lin_cmd = sat16(err_q >>> 1);
    end
    ang_cmd = sat16(-ErrW'(lat_q));
  end

  // tick count and search decisions
  always_comb begin
    d_wide      = (quiet_q > T20) ? '0 : {1'b0, quiet_q} + (QuietW + 1)'(1);
    d           = d_wide[QuietW] ? '1 : d_wide[QuietW-1:0];
    hunting     = !seen_q && !sweep_q;
    turn_neg_d  = hunting && (d >= T2) && (d <= T8);
    turn_pos_d  = hunting && (d > T8) && (d <= T14);
    set_sweep_d = hunting && (d == T14);
    drop_d      = seen_q && (d >= T3);
  end

  // controller state update
  always_comb begin
    seen_d     = seen_q;
    reached_d  = reached_q;
    sweep_d    = sweep_q;
    quiet_d    = quiet_q;
    held_lin_d = held_lin_q;
    held_ang_d = held_ang_q;
    case (op_i)
      OP_SAMPLE: begin
        seen_d  = 1'b1;
        sweep_d = 1'b0;
        quiet_d = '0;
        if (near_q) begin
          held_lin_d = '0;
          held_ang_d = '0;
          reached_d  = 1'b1;
        end else begin
          reached_d = 1'b0;
          if (!obst_q) begin
            held_lin_d = lin_cmd;
            held_ang_d = ang_cmd;
          end
        end
      end
      OP_TICK_CNT: begin
        quiet_d = d;
      end
      OP_TICK_CMD: begin
        if (turn_neg_q) begin
          held_lin_d = '0;
          held_ang_d = TurnNeg;
        end else if (turn_pos_q) begin
          held_lin_d = '0;
          held_ang_d = TurnPos;
        end
      end
      OP_TICK_POST: begin
        if (set_sweep_q) begin
          sweep_d = 1'b1;
        end
        if (drop_q) begin
          seen_d  = 1'b0;
          sweep_d = 1'b0;
          quiet_d = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // result handshake
  assign out_busy = out_valid_q && !out_ready_i;
  assign out_load = (op_i == OP_EMIT) && !out_busy;

  // state with reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= 1'b0;
      reached_q   <= 1'b0;
      sweep_q     <= 1'b0;
      quiet_q     <= '0;
      held_lin_q  <= '0;
      held_ang_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      seen_q     <= seen_d;
      reached_q  <= reached_d;
      sweep_q    <= sweep_d;
      quiet_q    <= quiet_d;
      held_lin_q <= held_lin_d;
      held_ang_q <= held_ang_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // tick decision flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      turn_neg_q  <= 1'b0;
      turn_pos_q  <= 1'b0;
      set_sweep_q <= 1'b0;
      drop_q      <= 1'b0;
    end else if (op_i == OP_TICK_CNT) begin
      turn_neg_q  <= turn_neg_d;
      turn_pos_q  <= turn_pos_d;
      set_sweep_q <= set_sweep_d;
      drop_q      <= drop_d;
    end
  end

  // latched item kind
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= 1'b0;
    end else if (op_i == OP_LATCH && in_valid_i) begin
      tick_q <= (in_word_i.operation == ITEM_TICK);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (op_i == OP_LATCH && in_valid_i) begin
      fwd_q  <= in_word_i.marker_forward;
      lat_q  <= in_word_i.marker_lateral;
      obst_q <= in_word_i.obstacle_present;
    end
    if (op_i == OP_SQ_F || op_i == OP_SQ_L) begin
      acc_q <= acc_d;
    end
    if (op_i == OP_TENTHS) begin
      x_q <= x_d;
    end
    if (op_i == OP_RECIP) begin
      prod_q <= x_q * RecipW'(RecipMul);
    end
    if (op_i == OP_RANGE) begin
      range_q <= range_d;
    end
    if (op_i == OP_ERR) begin
      err_q   <= err_d;
      near_q  <= near_d;
      big_q   <= big_d;
      small_q <= small_d;
    end
    if (out_load) begin
      out_word_q.linear_speed  <= held_lin_q;
      out_word_q.angular_speed <= held_ang_q;
      out_word_q.at_target     <= reached_q;
      out_word_q.marker_seen   <= seen_q;
      out_word_q.search_done   <= sweep_q;
    end
  end

  assign out_word_o  = out_word_q;
  assign out_valid_o = out_valid_q;

  assign status_o.in_valid  = in_valid_i;
  assign status_o.is_tick   = tick_q;
  assign status_o.root_busy = root_busy;
  assign status_o.out_busy  = out_busy;
  assign status_o.no_emit   = !(turn_neg_q || turn_pos_q);
endmodule

### src/marker_follow_speed_controller.sv
// top level of the marker follow speed controller
//
//   channel  dir  handshake      word
//   in_i     in   valid/ready    operation, marker_forward, marker_lateral, obstacle_present
//   out_o    out  valid/ready    linear_speed, angular_speed, at_target, marker_seen,
//                                search_done
//   cfg      in   cfg_we_i       target_distance on cfg_data_i
//
// one word at a time: ready returns only after a sample has passed the bit-serial square root
// and the later steps, or after a tick has run its count, command, emit if any, and post steps
// the microcode waits in its emit step while the previous result is still held
// a tick that commands no turn gives no result word
// reset clears all controller state and loads the default target; no clearing pass
module marker_follow_speed_controller #(
  parameter int TicksPerSecond = mfsc_pkg::DefTicksPerSecond,
  parameter int FractionBits   = mfsc_pkg::DefFractionBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  mfsc_in_if.sink                       in_i,
  mfsc_out_if.source                    out_o,
  input  logic                          cfg_we_i,
  input  logic [mfsc_pkg::TargetW-1:0]  cfg_data_i
);
  import mfsc_pkg::*;

  logic [TargetW-1:0] target_q;
  dp_op_e             op;
  status_t            status;
  logic               idle;
  in_word_t           in_word;
  out_word_t          out_word;
  logic               out_valid;

  // target distance register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= TargetReset;
    end else if (cfg_we_i) begin
      target_q <= cfg_data_i;
    end
  end

  // channel mapping
  assign in_word.operation        = in_i.operation;
  assign in_word.marker_forward   = in_i.marker_forward;
  assign in_word.marker_lateral   = in_i.marker_lateral;
  assign in_word.obstacle_present = in_i.obstacle_present;
  assign in_i.ready               = idle;

  assign out_o.valid         = out_valid;
  assign out_o.linear_speed  = out_word.linear_speed;
  assign out_o.angular_speed = out_word.angular_speed;
  assign out_o.at_target     = out_word.at_target;
  assign out_o.marker_seen   = out_word.marker_seen;
  assign out_o.search_done   = out_word.search_done;

  mfsc_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .op_o     (op),
    .idle_o   (idle)
  );

  mfsc_dp #(
    .TicksPerSecond (TicksPerSecond),
    .FractionBits   (FractionBits)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .in_word_i   (in_word),
    .in_valid_i  (in_i.valid),
    .target_i    (target_q),
    .out_ready_i (out_o.ready),
    .out_word_o  (out_word),
    .out_valid_o (out_valid),
    .status_o    (status)
  );

`ifndef NO_ASSERTIONS
  // one word at a time: no accept right after an accept
  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input accepted while previous word still in work");

  // the root unit is never running while the sequencer waits for a word
  a_root_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !status.root_busy)
    else $error("square root busy while idle");

  // a new result appears only out of an emit step
  a_emit_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(op == OP_EMIT))
    else $error("result valid without emit step");
`endif
endmodule
